// ===== hw/rtl/oqpi_pkg.sv =====
// Shared types and constants for the ordered queue with positional insert.
package oqpi_pkg;

    localparam int DEFAULT_CAPACITY   = 64;
    localparam int DEFAULT_DATA_WIDTH = 16;

    localparam int REQ_TYPE_W  = 2;
    localparam int POS_W       = 7;
    localparam int COORD_W     = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int ERR_W       = 2;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_SEARCH = 2'd3
    } req_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_EMPTY    = 2'd1,
        ERR_POSITION = 2'd2,
        ERR_FULL     = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_REMOVE,
        ST_SCAN,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]     removed_x;
        logic [COORD_W-1:0]     removed_y;
        logic                   found;
        logic [COUNT_OUT_W-1:0] entry_count;
        err_t                   error_code;
    } res_t;

endpackage

// ===== hw/rtl/oqpi_req_if.sv =====
// Request channel: valid/ready handshake with the request word.
interface oqpi_req_if;
    logic                                  valid;
    logic                                  ready;
    logic        [oqpi_pkg::REQ_TYPE_W-1:0] req_type;
    logic        [oqpi_pkg::POS_W-1:0]      position;
    logic signed [oqpi_pkg::COORD_W-1:0]    item_x;
    logic signed [oqpi_pkg::COORD_W-1:0]    item_y;

    modport source (output valid, req_type, position, item_x, item_y, input ready);
    modport sink   (input valid, req_type, position, item_x, item_y, output ready);
endinterface

// ===== hw/rtl/oqpi_rsp_if.sv =====
// Response channel: valid/ready handshake with the result word.
interface oqpi_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [oqpi_pkg::COORD_W-1:0]     removed_x;
    logic signed [oqpi_pkg::COORD_W-1:0]     removed_y;
    logic                                   found;
    logic        [oqpi_pkg::COUNT_OUT_W-1:0] entry_count;
    logic        [oqpi_pkg::ERR_W-1:0]       error_code;

    modport source (output valid, removed_x, removed_y, found, entry_count, error_code,
                    input ready);
    modport sink   (input valid, removed_x, removed_y, found, entry_count, error_code,
                    output ready);
endinterface

// ===== hw/rtl/oqpi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
module oqpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/oqpi_engine.sv =====
// Request sequencer: circular-buffer addressing, insert shifting, search scan.
module oqpi_engine #(
    parameter int CAPACITY   = oqpi_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = oqpi_pkg::DEFAULT_DATA_WIDTH,
    localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int MW        = 2 * DATA_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    oqpi_req_if.sink       req,
    output logic           mem_we,
    output logic [AW-1:0]  mem_waddr,
    output logic [MW-1:0]  mem_wdata,
    output logic [AW-1:0]  mem_raddr,
    input  logic [MW-1:0]  mem_rdata,
    output logic           res_valid,
    input  logic           res_ready,
    output oqpi_pkg::res_t res
);

    localparam int PCW = (CW > oqpi_pkg::POS_W) ? CW : oqpi_pkg::POS_W;

    oqpi_pkg::eng_state_t state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [oqpi_pkg::COORD_W-1:0] rem_x_reg, rem_x_next;
    logic [oqpi_pkg::COORD_W-1:0] rem_y_reg, rem_y_next;
    logic                  found_reg, found_next;
    oqpi_pkg::err_t        err_reg, err_next;

    logic [DATA_WIDTH-1:0] in_x;
    logic [DATA_WIDTH-1:0] in_y;
    logic                  full;
    logic [PCW-1:0]        pos_ext;
    logic [PCW-1:0]        cnt_ext;

    // logical index -> physical address, head-relative with one wrap
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW+1)'(idx);
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign in_x    = DATA_WIDTH'($unsigned(req.item_x));
    assign in_y    = DATA_WIDTH'($unsigned(req.item_y));
    assign full    = (count_reg == CW'(CAPACITY));
    assign pos_ext = PCW'(req.position);
    assign cnt_ext = PCW'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        found_next = found_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_waddr  = phys(head_reg, count_reg);
        mem_wdata  = {in_x, in_y};
        mem_raddr  = head_reg;
        res_valid  = 1'b0;
        req.ready  = (state_reg == oqpi_pkg::ST_IDLE);

        unique case (state_reg)
            oqpi_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    rem_x_next = '0;
                    rem_y_next = '0;
                    found_next = 1'b0;
                    err_next   = oqpi_pkg::ERR_NONE;
                    x_next     = in_x;
                    y_next     = in_y;
                    pos_next   = CW'(req.position);
                    state_next = oqpi_pkg::ST_DONE;
                    unique case (oqpi_pkg::req_kind_t'(req.req_type))
                        oqpi_pkg::REQ_APPEND:
                        begin
                            if (full)
                            begin
                                err_next = oqpi_pkg::ERR_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        oqpi_pkg::REQ_INSERT:
                        begin
                            priority if (pos_ext > cnt_ext)
                            begin
                                err_next = oqpi_pkg::ERR_POSITION;
                            end
                            else if (full)
                            begin
                                err_next = oqpi_pkg::ERR_FULL;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                mem_raddr  = phys(head_reg, count_reg - CW'(1));
                                idx_next   = count_reg - CW'(1);
                                state_next = oqpi_pkg::ST_SHIFT;
                            end
                        end
                        oqpi_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = oqpi_pkg::ERR_EMPTY;
                            end
                            else
                            begin
                                state_next = oqpi_pkg::ST_REMOVE;
                            end
                        end
                        oqpi_pkg::REQ_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = oqpi_pkg::ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            oqpi_pkg::ST_SHIFT:
            begin
                // rdata holds entry idx; move it back one slot, read the next lower one
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg + CW'(1));
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = oqpi_pkg::ST_PLACE;
                end
                else
                begin
                    mem_raddr = phys(head_reg, idx_reg - CW'(1));
                    idx_next  = idx_reg - CW'(1);
                end
            end
            oqpi_pkg::ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, pos_reg);
                mem_wdata  = {x_reg, y_reg};
                count_next = count_reg + CW'(1);
                state_next = oqpi_pkg::ST_DONE;
            end
            oqpi_pkg::ST_REMOVE:
            begin
                rem_x_next = oqpi_pkg::COORD_W'(mem_rdata[MW-1:DATA_WIDTH]);
                rem_y_next = oqpi_pkg::COORD_W'(mem_rdata[DATA_WIDTH-1:0]);
                head_next  = phys(head_reg, CW'(1));
                count_next = count_reg - CW'(1);
                state_next = oqpi_pkg::ST_DONE;
            end
            oqpi_pkg::ST_SCAN:
            begin
                if (mem_rdata == {x_reg, y_reg})
                begin
                    found_next = 1'b1;
                end
                if (idx_reg == count_reg - CW'(1))
                begin
                    state_next = oqpi_pkg::ST_DONE;
                end
                else
                begin
                    mem_raddr = phys(head_reg, idx_reg + CW'(1));
                    idx_next  = idx_reg + CW'(1);
                end
            end
            oqpi_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = oqpi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oqpi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oqpi_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        found_reg <= found_next;
        err_reg   <= err_next;
    end

    assign res.removed_x   = rem_x_reg;
    assign res.removed_y   = rem_y_reg;
    assign res.found       = found_reg;
    assign res.entry_count = oqpi_pkg::COUNT_OUT_W'(count_reg);
    assign res.error_code  = err_reg;

endmodule

// ===== hw/rtl/ordered_queue_with_positional_insert_unit.sv =====
// Top level: ordered queue with positional insert, remove-head and search.
// The list lives in one RAM of CAPACITY words of two coordinates, used as a
// circular buffer, so append and remove-head take no shifting. Every request
// gives one response word. Insert at position p into n entries moves the n - p
// entries from p onward up by one slot (p = n acts as append, with no moves);
// search compares all n entries. The single RAM read port sets the pace:
// insert moves one entry per cycle and search compares one entry per cycle.
// A new request is accepted once the previous result has moved into the output
// register, even while that word waits to be taken. No clearing pass after
// reset: entries beyond the count are never read.
module ordered_queue_with_positional_insert_unit #(
    parameter int CAPACITY   = oqpi_pkg::DEFAULT_CAPACITY,
    parameter int DATA_WIDTH = oqpi_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    oqpi_req_if.sink   req,
    oqpi_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MW = 2 * DATA_WIDTH;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem_rdata;

    logic           res_valid;
    logic           res_ready;
    oqpi_pkg::res_t res;

    logic           out_valid_reg, out_valid_next;
    oqpi_pkg::res_t out_word_reg;

    oqpi_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    oqpi_ram #(
        .WIDTH (MW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.removed_x   = out_word_reg.removed_x;
    assign rsp.removed_y   = out_word_reg.removed_y;
    assign rsp.found       = out_word_reg.found;
    assign rsp.entry_count = out_word_reg.entry_count;
    assign rsp.error_code  = out_word_reg.error_code;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ordered queue unit: directed and random requests checked against a list model.
module tb_top;
    import oqpi_pkg::*;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int RANDOM_WORDS = 528;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int SEND_IDLE[4]  = '{0, 84, 0, 14};
    localparam int RECV_STALL[4] = '{0, 0, 84, 14};

    typedef struct {
        req_kind_t                 kind;
        logic [POS_W-1:0]          position;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } request_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } point_t;

    class list_tracker;
        point_t entries[$];
        res_t   pending_results[$];
        int     mismatches;
        int     checked;
        int     err_tally[4];
        int     hits;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function void note_request(request_t r);
            res_t   exp;
            point_t p;
            int     n;
            n = entries.size();
            p.x = r.x;
            p.y = r.y;
            exp = '0;
            case (r.kind)
                REQ_APPEND:
                begin
                    if (n >= CAP)
                        exp.error_code = ERR_FULL;
                    else
                        entries.push_back(p);
                end
                REQ_INSERT:
                begin
                    if (r.position > n)
                        exp.error_code = ERR_POSITION;
                    else if (n >= CAP)
                        exp.error_code = ERR_FULL;
                    else
                        entries.insert(int'(r.position), p);
                end
                REQ_REMOVE:
                begin
                    if (n == 0)
                        exp.error_code = ERR_EMPTY;
                    else
                    begin
                        p = entries.pop_front();
                        exp.removed_x = p.x;
                        exp.removed_y = p.y;
                    end
                end
                default:
                begin
                    foreach (entries[i])
                        if (entries[i] == p)
                            exp.found = 1'b1;
                end
            endcase
            exp.entry_count = COUNT_OUT_W'(entries.size());
            err_tally[exp.error_code]++;
            if (exp.found)
                hits++;
            pending_results.push_back(exp);
        endfunction

        task check_result(res_t got);
            res_t exp;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result word with nothing pending (count %0d, err %0d)",
                                 got.entry_count, got.error_code));
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            if (got.removed_x !== exp.removed_x)
                report($sformatf("removed_x %h, want %h", got.removed_x, exp.removed_x));
            if (got.removed_y !== exp.removed_y)
                report($sformatf("removed_y %h, want %h", got.removed_y, exp.removed_y));
            if (got.found !== exp.found)
                report($sformatf("found %b, want %b", got.found, exp.found));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("entry_count %0d, want %0d", got.entry_count,
                                 exp.entry_count));
            if (got.error_code !== exp.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code, exp.error_code));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        hold_off = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          filling = 1'b1;
    list_tracker tracker = new();

    oqpi_req_if req_bus();
    oqpi_rsp_if rsp_bus();

    ordered_queue_with_positional_insert_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d result words outstanding", tracker.pending_results.size());
        $display("tb_top failed");
        $finish;
    end

    function automatic request_t make_req(req_kind_t k, int pos, int x, int y);
        request_t r;
        r.kind     = k;
        r.position = pos[POS_W-1:0];
        r.x        = x[COORD_W-1:0];
        r.y        = y[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(19))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return '1;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // grows toward full, then drains toward empty, lingering a little at each end
    function automatic request_t next_request();
        request_t r;
        int       n;
        int       roll;
        int       k;
        n = tracker.entries.size();
        if (n == CAP && $urandom_range(3) == 0)
            filling = 1'b0;
        if (n == 0 && $urandom_range(3) == 0)
            filling = 1'b1;
        roll       = $urandom_range(99);
        r.position = POS_W'($urandom());
        r.x        = pick_coord();
        r.y        = pick_coord();
        if (roll < 10)
        begin
            r.kind = REQ_SEARCH;
            if (n > 0 && roll < 6)
            begin
                k   = $urandom_range(n - 1);
                r.x = tracker.entries[k].x;
                r.y = tracker.entries[k].y;
                if (roll == 5)
                    r.y = COORD_W'(r.y + 1);
            end
        end
        else if (filling ? roll < 15 : roll < 85)
            r.kind = REQ_REMOVE;
        else if ($urandom_range(4) < 2)
            r.kind = REQ_APPEND;
        else
        begin
            r.kind = REQ_INSERT;
            case ($urandom_range(9))
                0: r.position = POS_W'($urandom_range(127));
                1: r.position = POS_W'(n);
                2: r.position = POS_W'(n + 1);
                default: r.position = POS_W'($urandom_range(n));
            endcase
        end
        return r;
    endfunction

    task automatic send_word(input request_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= r.kind;
        req_bus.position <= r.position;
        req_bus.item_x   <= r.x;
        req_bus.item_y   <= r.y;
        do
            @(posedge clk);
        while (!req_bus.ready);
        tracker.note_request(r);
    endtask

    task automatic hold_receiver();
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    initial
    begin : response_side
        res_t got;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                got.removed_x   = rsp_bus.removed_x;
                got.removed_y   = rsp_bus.removed_y;
                got.found       = rsp_bus.found;
                got.entry_count = rsp_bus.entry_count;
                got.error_code  = err_t'(rsp_bus.error_code);
                tracker.check_result(got);
            end
            rsp_bus.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        int ph;
        int i;
        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_APPEND;
        req_bus.position <= '0;
        req_bus.item_x   <= '0;
        req_bus.item_y   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_req(REQ_REMOVE, 0, 0, 0));           // remove when empty
        send_word(make_req(REQ_SEARCH, 0, 0, 0));           // search of empty list
        send_word(make_req(REQ_INSERT, 1, 5, 5));           // position past count
        send_word(make_req(REQ_INSERT, 127, -1, -1));
        send_word(make_req(REQ_INSERT, 0, -32768, 32767));
        send_word(make_req(REQ_APPEND, 127, 32767, -32768));
        send_word(make_req(REQ_APPEND, 0, -1, -1));
        send_word(make_req(REQ_INSERT, 3, 0, 0));           // insert at tail
        send_word(make_req(REQ_INSERT, 1, 1234, -5678));
        send_word(make_req(REQ_INSERT, 6, 9, 9));           // one past count
        send_word(make_req(REQ_SEARCH, 0, 32767, -32768));
        send_word(make_req(REQ_SEARCH, 0, 32767, 0));       // x matches only
        send_word(make_req(REQ_SEARCH, 0, 0, 0));           // hit on tail
        send_word(make_req(REQ_SEARCH, 127, -32768, 32767)); // hit on head
        send_word(make_req(REQ_REMOVE, 0, 0, 0));
        send_word(make_req(REQ_SEARCH, 0, -32768, 32767));  // removed entry
        send_word(make_req(REQ_INSERT, 64, 1, 1));
        send_word(make_req(REQ_INSERT, 0, 2, 2));
        repeat (6) send_word(make_req(REQ_REMOVE, 0, 0, 0));

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            recv_stall_pct <= RECV_STALL[ph];
            for (i = 0; i < RANDOM_WORDS / 4; i++)
            begin
                if (ph == 0 && i == 30)
                    fork
                        hold_receiver();
                    join_none
                send_word(next_request());
            end
        end
        req_bus.valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words: %0d ok, %0d empty removes, %0d bad positions, %0d full",
                 tracker.checked, tracker.err_tally[ERR_NONE], tracker.err_tally[ERR_EMPTY],
                 tracker.err_tally[ERR_POSITION], tracker.err_tally[ERR_FULL]);
        $display("Search hits %0d; idle mixes plus a %0d-cycle receiver hold-off; %0d mismatches",
                 tracker.hits, HOLD_CYCLES, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
